[rtl/ppep_pkg.sv]
// shared types, constants and helper functions for the pixel plane extract/pack block
// no dependencies; used by every module in rtl/
`default_nettype none

package ppep_pkg;

  localparam int DEF_MAX_ROW_WIDTH = 4096;
  localparam int ROW_W             = 13;
  localparam int PIX_W             = 8;
  localparam int WORD_W            = 32;
  localparam int BITS_W            = 6;
  localparam int CFG_DATA_W        = 13;
  localparam int CFG_IDX_W         = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_FORMAT   = 3'd0,
    CFG_PLANE_MASK     = 3'd1,
    CFG_ROW_WIDTH      = 3'd2,
    CFG_BIT_ORDER_MODE = 3'd3,
    CFG_UNIT_SIZE_CODE = 3'd4
  } cfg_idx_t;

  localparam logic FMT_PIXEL   = 1'b0;
  localparam logic FMT_PLANE   = 1'b1;
  localparam logic ORDER_SHIFT = 1'b0;
  localparam logic ORDER_PLACE = 1'b1;

  localparam logic [1:0] UNIT_CODE_8  = 2'd0;
  localparam logic [1:0] UNIT_CODE_16 = 2'd1;
  localparam logic [1:0] UNIT_CODE_32 = 2'd2;

  typedef struct packed {
    logic                image_format;
    logic [PIX_W-1:0]    plane_mask;
    logic                bit_order;
    logic [BITS_W-1:0]   unit_bits;
    logic [2:0]          plane_idx;
    logic                plane_none;
  } cfg_t;

  function automatic logic [BITS_W-1:0] unit_bits_of(input logic [1:0] code);
    logic [BITS_W-1:0] u;
    case (code)
      UNIT_CODE_8:  u = 6'd8;
      UNIT_CODE_16: u = 6'd16;
      default:      u = 6'd32;
    endcase
    return u;
  endfunction

  function automatic logic [WORD_W-1:0] unit_mask_of(input logic [BITS_W-1:0] u);
    logic [WORD_W-1:0] m;
    if (u == 6'd8) begin
      m = 32'h0000_00FF;
    end else if (u == 6'd16) begin
      m = 32'h0000_FFFF;
    end else begin
      m = 32'hFFFF_FFFF;
    end
    return m;
  endfunction

  // index of the lowest set mask bit
  function automatic logic [2:0] lowest_set(input logic [PIX_W-1:0] mask);
    logic [2:0] idx;
    idx = 3'd0;
    for (int p = PIX_W - 1; p >= 0; p--) begin
      if (mask[p]) begin
        idx = 3'(p);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/ppep_cfg_regs.sv]
// configuration registers and decoded settings for the pixel plane extract/pack block
// depends on ppep_pkg
`default_nettype none

module ppep_cfg_regs #(
  parameter int MAX_ROW_WIDTH = ppep_pkg::DEF_MAX_ROW_WIDTH,
  localparam int WW = ($clog2(MAX_ROW_WIDTH + 1) > ppep_pkg::ROW_W) ?
                      $clog2(MAX_ROW_WIDTH + 1) : ppep_pkg::ROW_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ppep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppep_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output ppep_pkg::cfg_t                       cfg,
  output logic [WW-1:0]                        eff_width
);

  logic                           image_format_r;
  logic [ppep_pkg::PIX_W-1:0]     plane_mask_r;
  logic [ppep_pkg::ROW_W-1:0]     row_width_r;
  logic                           bit_order_r;
  logic [1:0]                     unit_code_r;
  logic [WW-1:0]                  width_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_format_r <= ppep_pkg::FMT_PIXEL;
      plane_mask_r   <= 8'hFF;
      row_width_r    <= 13'd1;
      bit_order_r    <= ppep_pkg::ORDER_PLACE;
      unit_code_r    <= ppep_pkg::UNIT_CODE_32;
    end else if (cfg_wr_en) begin
      unique case (ppep_pkg::cfg_idx_t'(cfg_index))
        ppep_pkg::CFG_IMAGE_FORMAT:   image_format_r <= cfg_wr_data[0];
        ppep_pkg::CFG_PLANE_MASK:     plane_mask_r   <= cfg_wr_data[7:0];
        ppep_pkg::CFG_ROW_WIDTH:      row_width_r    <= cfg_wr_data[12:0];
        ppep_pkg::CFG_BIT_ORDER_MODE: bit_order_r    <= cfg_wr_data[0];
        ppep_pkg::CFG_UNIT_SIZE_CODE: unit_code_r    <= cfg_wr_data[1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one, large widths saturate
  always_comb begin
    width_base = (row_width_r == '0) ? WW'(1) : WW'(row_width_r);
    if (width_base > WW'(MAX_ROW_WIDTH)) begin
      eff_width = WW'(MAX_ROW_WIDTH);
    end else begin
      eff_width = width_base;
    end
  end

  always_comb begin
    cfg.image_format = image_format_r;
    cfg.plane_mask   = plane_mask_r;
    cfg.bit_order    = bit_order_r;
    cfg.unit_bits    = ppep_pkg::unit_bits_of(unit_code_r);
    cfg.plane_idx    = ppep_pkg::lowest_set(plane_mask_r);
    cfg.plane_none   = (plane_mask_r == '0);
  end

endmodule

`default_nettype wire

[rtl/ppep_pack_unit.sv]
// column counter, plane bit extraction and unit packing state
// depends on ppep_pkg
`default_nettype none

module ppep_pack_unit #(
  parameter int MAX_ROW_WIDTH = ppep_pkg::DEF_MAX_ROW_WIDTH,
  localparam int WW = ($clog2(MAX_ROW_WIDTH + 1) > ppep_pkg::ROW_W) ?
                      $clog2(MAX_ROW_WIDTH + 1) : ppep_pkg::ROW_W,
  localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  ppep_pkg::cfg_t                     cfg,
  input  wire logic [WW-1:0]                 eff_width,
  input  wire logic                          step,
  input  wire logic [ppep_pkg::PIX_W-1:0]    pixel,
  output logic                               res_produce,
  output logic [ppep_pkg::WORD_W-1:0]        res_word,
  output logic                               res_end_of_row
);

  logic [ppep_pkg::WORD_W-1:0]  acc_r, acc_nxt;
  logic [ppep_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic [COL_W-1:0]             col_r, col_nxt;

  logic [WW:0]                  col_inc;
  logic                         row_end;
  logic [ppep_pkg::WORD_W-1:0]  umask;
  logic [ppep_pkg::WORD_W-1:0]  acc_base;
  logic [ppep_pkg::BITS_W-1:0]  bits_base;
  logic [ppep_pkg::BITS_W-1:0]  bits_new;
  logic [ppep_pkg::WORD_W-1:0]  acc_new;
  logic [4:0]                   place_pos;
  logic                         plane_bit;
  logic                         plane_emit;

  always_comb begin
    col_inc  = (WW + 1)'(col_r) + 1'b1;
    row_end  = (col_inc >= {1'b0, eff_width});
    col_nxt  = row_end ? '0 : col_inc[COL_W-1:0];

    umask     = ppep_pkg::unit_mask_of(cfg.unit_bits);
    // a unit that shrank below its fill level is dropped
    if (bits_r >= cfg.unit_bits) begin
      acc_base  = '0;
      bits_base = '0;
    end else begin
      acc_base  = acc_r;
      bits_base = bits_r;
    end

    plane_bit = cfg.plane_none ? 1'b0 : pixel[cfg.plane_idx];
    place_pos = 5'(cfg.unit_bits - 6'd1 - bits_base);
    if (cfg.bit_order == ppep_pkg::ORDER_SHIFT) begin
      acc_new = {acc_base[ppep_pkg::WORD_W-2:0], plane_bit} & umask;
    end else begin
      acc_new = (acc_base | (ppep_pkg::WORD_W'(plane_bit) << place_pos)) & umask;
    end
    bits_new   = bits_base + 6'd1;
    plane_emit = (bits_new >= cfg.unit_bits) || row_end;

    if (cfg.image_format == ppep_pkg::FMT_PIXEL) begin
      res_produce = 1'b1;
      res_word    = ppep_pkg::WORD_W'(pixel & cfg.plane_mask);
      acc_nxt     = acc_r;
      bits_nxt    = bits_r;
    end else begin
      res_produce = plane_emit;
      res_word    = acc_new;
      acc_nxt     = plane_emit ? '0 : acc_new;
      bits_nxt    = plane_emit ? '0 : bits_new;
    end
    res_end_of_row = row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      bits_r <= '0;
      col_r  <= '0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      bits_r <= bits_nxt;
      col_r  <= col_nxt;
    end
  end

  a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= 6'd32)
    else $error("unit fill level above 32");

  a_partial_below_unit: assert property (@(posedge clk) disable iff (!rst_n)
    step && cfg.image_format == ppep_pkg::FMT_PLANE && !res_produce
    |-> bits_nxt < cfg.unit_bits)
    else $error("full unit kept without being emitted");

  a_pixel_mode_keeps_pack: assert property (@(posedge clk) disable iff (!rst_n)
    step && cfg.image_format == ppep_pkg::FMT_PIXEL |=> $stable(acc_r) && $stable(bits_r))
    else $error("pixel mode changed packing state");

endmodule

`default_nettype wire

[rtl/pixel_plane_extract_pack_core.sv]
// top level of the pixel plane extract/pack block: input register, result register
// depends on ppep_pkg, ppep_cfg_regs, ppep_pack_unit
`default_nettype none

// Takes one 8-bit pixel per cycle in raster order, one item per clock unless in_stall holds it.
// An accepted pixel is held in the input register and its result is then loaded into
// the output register, where it is offered as a result; the column counter and the
// packing accumulator update when the pixel leaves the input register.
// A result held by out_stall stalls the input only when the waiting pixel also makes a
// result. Pixel mode gives one result per pixel; plane mode gives one result per full
// 8/16/32-bit unit or at row end. Configuration is to be written only while no item is
// in flight.
module pixel_plane_extract_pack_core #(
  parameter int MAX_ROW_WIDTH = ppep_pkg::DEF_MAX_ROW_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ppep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppep_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ppep_pkg::PIX_W-1:0]      in_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ppep_pkg::WORD_W-1:0]          out_data_word,
  output logic                                 out_end_of_row
);

  localparam int WW = ($clog2(MAX_ROW_WIDTH + 1) > ppep_pkg::ROW_W) ?
                      $clog2(MAX_ROW_WIDTH + 1) : ppep_pkg::ROW_W;

  ppep_pkg::cfg_t               cfg;
  logic [WW-1:0]                eff_width;

  logic                         s1_valid_r, s1_valid_nxt;
  logic [ppep_pkg::PIX_W-1:0]   s1_pixel_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [ppep_pkg::WORD_W-1:0]  out_word_r;
  logic                         out_eor_r;

  logic                         res_produce;
  logic [ppep_pkg::WORD_W-1:0]  res_word;
  logic                         res_eor;
  logic                         out_free;
  logic                         advance;
  logic                         load_out;
  logic                         in_take;

  ppep_cfg_regs #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg),
    .eff_width   (eff_width)
  );

  ppep_pack_unit #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_pack (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .eff_width      (eff_width),
    .step           (advance),
    .pixel          (s1_pixel_r),
    .res_produce    (res_produce),
    .res_word       (res_word),
    .res_end_of_row (res_eor)
  );

  // an item with no result moves on even when the output is blocked
  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    advance       = s1_valid_r && (out_free || !res_produce);
    load_out      = advance && res_produce;
    in_stall      = s1_valid_r && !advance;
    in_take       = in_valid && !in_stall;
    s1_valid_nxt  = in_take || (s1_valid_r && !advance);
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_pixel;
    end
    if (load_out) begin
      out_word_r <= res_word;
      out_eor_r  <= res_eor;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_word  = out_word_r;
  assign out_end_of_row = out_eor_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !load_out)
    else $error("waiting result overwritten");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && res_produce)
    else $error("input stalled with nothing blocking");

  a_pixel_low_byte: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && cfg.image_format == ppep_pkg::FMT_PIXEL |=> out_data_word[31:8] == '0)
    else $error("pixel result wider than a byte");

  a_unit_width: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && cfg.image_format == ppep_pkg::FMT_PLANE && cfg.unit_bits == 6'd8
    |=> out_data_word[31:8] == '0)
    else $error("packed byte unit has high bits set");

endmodule

`default_nettype wire

[bench/plane_pack_checker.sv]
// checker for pixel_plane_extract_pack_core: watches the config port and both channels,
// predicts every result and compares it field by field; depends on ppep_pkg only
`timescale 1ns / 1ps

module plane_pack_checker #(
  parameter int MAX_ROW = ppep_pkg::DEF_MAX_ROW_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ppep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppep_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic [ppep_pkg::PIX_W-1:0]      in_pixel,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic [ppep_pkg::WORD_W-1:0]     out_data_word,
  input  wire logic                            out_end_of_row,
  output int                                   fault_count,
  output int                                   words_pending
);

  typedef struct packed {
    logic [ppep_pkg::WORD_W-1:0] word;
    logic                        eor;
  } row_word_t;

  row_word_t words_due[$];

  logic                       fmt_r;
  logic [ppep_pkg::PIX_W-1:0] mask_r;
  logic [ppep_pkg::ROW_W-1:0] width_r;
  logic                       order_r;
  logic [1:0]                 unit_code_r;

  logic [ppep_pkg::WORD_W-1:0] acc;
  int                          acc_bits;
  logic [ppep_pkg::ROW_W-1:0]  column;
  int                          faults = 0;

  task automatic pack_pixel(input logic [ppep_pkg::PIX_W-1:0] pix);
    int                          width;
    int                          u;
    bit                          row_end;
    bit                          found;
    logic                        b;
    logic [ppep_pkg::WORD_W-1:0] umask;
    row_word_t                   r;
    width = (width_r == 0) ? 1 : ((int'(width_r) > MAX_ROW) ? MAX_ROW : int'(width_r));
    row_end = (int'(column) + 1 >= width);
    column = row_end ? '0 : column + 1'b1;
    if (fmt_r == ppep_pkg::FMT_PIXEL) begin
      r.word = {24'd0, pix & mask_r};
      r.eor  = row_end;
      words_due.push_back(r);
    end else begin
      case (unit_code_r)
        ppep_pkg::UNIT_CODE_8:  u = 8;
        ppep_pkg::UNIT_CODE_16: u = 16;
        default:                u = 32;
      endcase
      umask = (u == 32) ? '1 : ((32'd1 << u) - 32'd1);
      if (acc_bits >= u) begin
        acc      = '0;
        acc_bits = 0;
      end
      // lowest set mask bit picks the plane, none set gives 0
      b = 1'b0;
      found = 1'b0;
      for (int p = 0; p < ppep_pkg::PIX_W; p++) begin
        if (!found && mask_r[p]) begin
          b = pix[p];
          found = 1'b1;
        end
      end
      if (order_r == ppep_pkg::ORDER_SHIFT) begin
        acc = ((acc << 1) | 32'(b)) & umask;
      end else begin
        acc = (acc | (32'(b) << (u - 1 - acc_bits))) & umask;
      end
      acc_bits++;
      if (acc_bits >= u || row_end) begin
        r.word = acc;
        r.eor  = row_end;
        words_due.push_back(r);
        acc      = '0;
        acc_bits = 0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    row_word_t want;
    if (!rst_n) begin
      fmt_r       = ppep_pkg::FMT_PIXEL;
      mask_r      = 8'hFF;
      width_r     = 13'd1;
      order_r     = ppep_pkg::ORDER_PLACE;
      unit_code_r = ppep_pkg::UNIT_CODE_32;
      acc         = '0;
      acc_bits    = 0;
      column      = '0;
      words_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual data_word %h end_of_row %b",
                   $time, out_data_word, out_end_of_row);
          faults++;
        end else begin
          want = words_due.pop_front();
          if (out_data_word !== want.word) begin
            $display("%0t: data_word mismatch: expected %h actual %h",
                     $time, want.word, out_data_word);
            faults++;
          end
          if (out_end_of_row !== want.eor) begin
            $display("%0t: end_of_row mismatch: expected %b actual %b",
                     $time, want.eor, out_end_of_row);
            faults++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          ppep_pkg::CFG_IMAGE_FORMAT:   fmt_r       = cfg_wr_data[0];
          ppep_pkg::CFG_PLANE_MASK:     mask_r      = cfg_wr_data[ppep_pkg::PIX_W-1:0];
          ppep_pkg::CFG_ROW_WIDTH:      width_r     = cfg_wr_data[ppep_pkg::ROW_W-1:0];
          ppep_pkg::CFG_BIT_ORDER_MODE: order_r     = cfg_wr_data[0];
          ppep_pkg::CFG_UNIT_SIZE_CODE: unit_code_r = cfg_wr_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pack_pixel(in_pixel);
      end
    end
    fault_count   <= faults;
    words_pending <= words_due.size();
  end

endmodule

[bench/testbench.sv]
// top of the bench: clock, reset, config writes, pixel stimulus, output stalls and verdict
// depends on ppep_pkg, pixel_plane_extract_pack_core and plane_pack_checker
`timescale 1ns / 1ps

module testbench;

  localparam int          QUIET_LIMIT   = 2000;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          CALM_PHASE    = 5;
  localparam int          LONG_ROW_PIX  = 60;
  localparam logic [2:0]  CFG_SPARE_LO  = 3'd5;
  localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [ppep_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ppep_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [ppep_pkg::PIX_W-1:0]      in_pixel = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ppep_pkg::WORD_W-1:0]     out_data_word;
  logic                            out_end_of_row;

  logic calm = 1'b0;
  int   fault_count;
  int   words_pending;
  int   quiet_cycles = 0;

  pixel_plane_extract_pack_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_word  (out_data_word),
    .out_end_of_row (out_end_of_row)
  );

  plane_pack_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_word  (out_data_word),
    .out_end_of_row (out_end_of_row),
    .fault_count    (fault_count),
    .words_pending  (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [ppep_pkg::PIX_W-1:0] p);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every predicted item is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ppep_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppep_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          sent;
    int          n;
    int          r;
    int          k;
    int          phase;
    logic [12:0] w;
    logic [7:0]  m;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: masked pixels, one pixel per row
    send_pixel(8'h00);
    send_pixel(8'hFF);
    settle();

    // zero mask and zero width in plane mode, reset order and unit
    write_reg(ppep_pkg::CFG_IMAGE_FORMAT, 13'(ppep_pkg::FMT_PLANE));
    write_reg(ppep_pkg::CFG_PLANE_MASK, 13'h0000);
    write_reg(ppep_pkg::CFG_ROW_WIDTH, 13'h0000);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    settle();

    // unit code 3 acts as 32, partial unit flushed at row end
    write_reg(ppep_pkg::CFG_PLANE_MASK, 13'h0080);
    write_reg(ppep_pkg::CFG_ROW_WIDTH, 13'd5);
    write_reg(ppep_pkg::CFG_BIT_ORDER_MODE, 13'(ppep_pkg::ORDER_SHIFT));
    write_reg(ppep_pkg::CFG_UNIT_SIZE_CODE, 13'h0003);
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'hFF);
    send_pixel(8'h7F);
    settle();

    // unit fills exactly at row end
    write_reg(ppep_pkg::CFG_PLANE_MASK, 13'h0006);
    write_reg(ppep_pkg::CFG_ROW_WIDTH, 13'd8);
    write_reg(ppep_pkg::CFG_BIT_ORDER_MODE, 13'(ppep_pkg::ORDER_PLACE));
    write_reg(ppep_pkg::CFG_UNIT_SIZE_CODE, 13'(ppep_pkg::UNIT_CODE_8));
    send_pixel(8'h02);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h02);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h02);
    send_pixel(8'hFD);
    settle();

    // unit shrunk below the pending bits, row width lowered under the column
    write_reg(ppep_pkg::CFG_ROW_WIDTH, 13'd20);
    write_reg(ppep_pkg::CFG_UNIT_SIZE_CODE, 13'(ppep_pkg::UNIT_CODE_16));
    repeat (9) send_pixel(8'($urandom));
    settle();
    write_reg(ppep_pkg::CFG_UNIT_SIZE_CODE, 13'(ppep_pkg::UNIT_CODE_8));
    write_reg(ppep_pkg::CFG_ROW_WIDTH, 13'd4);
    send_pixel(8'h02);
    settle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 60) begin
        w = 13'($urandom) & ~13'h1;
        write_reg(ppep_pkg::CFG_IMAGE_FORMAT, w | 13'($urandom_range(0, 99) < 70));
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 7);
        if (r < 6) begin
          m = 8'h00;
        end else if (r < 15) begin
          m = 8'hFF;
        end else if (r < 70) begin
          m = ((8'($urandom) >> k) << k) | (8'h01 << k);
        end else begin
          m = 8'($urandom);
        end
        write_reg(ppep_pkg::CFG_PLANE_MASK, {5'($urandom), m});
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          w = 13'd0;
        end else if (r < 65) begin
          w = 13'($urandom_range(1, 12));
        end else if (r < 95) begin
          w = 13'($urandom_range(13, 70));
        end else begin
          w = 13'($urandom_range(71, 300));
        end
        write_reg(ppep_pkg::CFG_ROW_WIDTH, w);
      end
      if ($urandom_range(0, 99) < 60) begin
        w = 13'($urandom) & ~13'h1;
        write_reg(ppep_pkg::CFG_BIT_ORDER_MODE, w | 13'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) < 60) begin
        w = 13'($urandom) & ~13'h3;
        write_reg(ppep_pkg::CFG_UNIT_SIZE_CODE, w | 13'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 99) < 10) begin
        write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 13'($urandom));
      end
      if (phase == CALM_PHASE) begin
        calm <= 1'b1;
        n = 200;
      end else begin
        n = $urandom_range(4, 60);
      end
      repeat (n) send_pixel(8'($urandom));
      sent += n;
      settle();
      calm <= 1'b0;
      phase++;
    end

    // width above the limit saturates, no row end within a long run
    write_reg(ppep_pkg::CFG_IMAGE_FORMAT, 13'(ppep_pkg::FMT_PLANE));
    write_reg(ppep_pkg::CFG_ROW_WIDTH, 13'h1FFF);
    write_reg(ppep_pkg::CFG_UNIT_SIZE_CODE, 13'(ppep_pkg::UNIT_CODE_8));
    write_reg(ppep_pkg::CFG_PLANE_MASK, 13'(8'h01 << $urandom_range(0, 7)));
    repeat (LONG_ROW_PIX) send_pixel(8'($urandom));
    settle();
    repeat (8) @(posedge clk);

    if (fault_count == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
